/* hw/rtl/tpci_pkg.sv */
// shared types, constants and helpers for the three-axis pid controller
package tpci_pkg;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  // register reset values
  localparam logic [15:0] PropGainRst  = 16'd307;
  localparam logic [15:0] IntegGainRst = 16'd13;
  localparam logic [15:0] DerivGainRst = 16'd102;
  localparam logic [15:0] StepTimeRst  = 16'd655;
  localparam logic [15:0] StepRateRst  = 16'd100;
  localparam logic [30:0] IntegLimRst  = 31'd327680;
  localparam logic [30:0] NormLimRst   = 31'd131072;
  localparam logic [15:0] MassScaleRst = 16'd256;

  // input actions
  typedef enum logic [1:0] {
    ACT_SET_TARGET = 2'd0,
    ACT_MEASURE    = 2'd1,
    ACT_TICK       = 2'd2
  } action_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_INTEG_GAIN   = 3'd1,
    CFG_DERIV_GAIN   = 3'd2,
    CFG_STEP_TIME    = 3'd3,
    CFG_STEP_RATE    = 3'd4,
    CFG_INTEG_LIMIT  = 3'd5,
    CFG_NORM_LIMIT   = 3'd6,
    CFG_MASS_SCALE   = 3'd7
  } cfg_idx_e;

  // tick sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL,
    ST_NORM,
    ST_CMP,
    ST_UPD,
    ST_TERM,
    ST_SUM,
    ST_MASS,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value_x;
    logic signed [31:0] value_y;
    logic signed [31:0] value_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } out_item_t;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [15:0] deriv_gain;
    logic [15:0] step_time;
    logic [15:0] step_rate;
    logic [30:0] integral_limit;
    logic [30:0] error_norm_limit;
    logic [15:0] mass_scale;
  } cfg_t;

  // step strobes from the sequencer to the lanes and the merge stage
  typedef struct packed {
    logic load_tgt;
    logic load_meas;
    logic step_err;
    logic step_mul;
    logic step_norm;
    logic step_cmp;
    logic step_upd;
    logic fresh;
    logic band;
    logic step_term;
    logic step_sum;
    logic step_mass;
  } ctrl_t;

  // saturate a signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/tpci_lane.sv */
// one axis lane: error, integral, derivative and force datapath
module tpci_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpci_pkg::ctrl_t     ctrl_i,
  input  tpci_pkg::cfg_t      cfg_i,
  input  logic signed [31:0]  value_i,
  output logic [63:0]         sq_o,
  output logic signed [31:0]  force_o
);
  import tpci_pkg::*;

  // controller state
  logic signed [31:0] target_q, meas_q, integ_q, last_err_q, deriv_q;
  logic signed [31:0] integ_d, deriv_d;
  // pipeline registers
  logic signed [31:0] err_q, err_d;
  logic [63:0]        sq_q, sq_d;
  logic signed [48:0] itp_q, itp_d;
  logic signed [49:0] drv_q, drv_d;
  logic signed [48:0] pt_q, pt_d, it_q, it_d, dt_q, dt_d;
  logic signed [42:0] u_q, u_d;
  logic signed [43:0] ph_q, ph_d;
  logic [31:0]        pl_q, pl_d;

  logic signed [32:0] err_wide, err_ext, diff;
  logic [31:0]        mag;
  logic signed [33:0] acc, lim;
  logic signed [50:0] term_sum;
  logic signed [59:0] f_full, f_shift;

  // error, saturated
  assign err_wide = 33'(target_q) - 33'(meas_q);
  assign err_d    = sat32(64'(err_wide));

  // squared magnitude and the two rate products
  assign err_ext = 33'(err_q);
  assign mag     = err_q[31] ? 32'(-err_ext) : 32'(err_q);
  assign sq_d    = 64'(mag) * 64'(mag);
  assign itp_d   = 49'(err_q) * 49'($signed({1'b0, cfg_i.step_time}));
  assign diff    = 33'(err_q) - 33'(last_err_q);
  assign drv_d   = 50'(diff) * 50'($signed({1'b0, cfg_i.step_rate}));

  // integral accumulate and clamp, or clear outside the band
  assign acc = 34'(integ_q) + 34'(itp_q >>> 16);
  assign lim = $signed({3'b000, cfg_i.integral_limit});
  always_comb begin
    if (!ctrl_i.band) begin
      integ_d = '0;
    end else if (acc > lim) begin
      integ_d = 32'(lim);
    end else if (acc < -lim) begin
      integ_d = 32'(-lim);
    end else begin
      integ_d = 32'(acc);
    end
  end
  assign deriv_d = sat32(64'(drv_q));

  // gain terms
  assign pt_d = 49'($signed({1'b0, cfg_i.prop_gain}))  * 49'(err_q);
  assign it_d = 49'($signed({1'b0, cfg_i.integ_gain})) * 49'(integ_q);
  assign dt_d = 49'($signed({1'b0, cfg_i.deriv_gain})) * 49'(deriv_q);

  // exact sum then floor shift to q16.16
  assign term_sum = 51'(pt_q) + 51'(it_q) + 51'(dt_q);
  assign u_d      = 43'(term_sum >>> 8);

  // mass scaling split into high and low partial products
  assign ph_d = 44'($signed(u_q[42:16])) * 44'($signed({1'b0, cfg_i.mass_scale}));
  assign pl_d = 32'(u_q[15:0]) * 32'(cfg_i.mass_scale);

  // recombine, floor shift and saturate
  assign f_full  = (60'(ph_q) <<< 16) + $signed({28'b0, pl_q});
  assign f_shift = f_full >>> 8;
  assign force_o = sat32(64'(f_shift));
  assign sq_o    = sq_q;

  // controller state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      meas_q     <= '0;
      integ_q    <= '0;
      last_err_q <= '0;
      deriv_q    <= '0;
    end else begin
      if (ctrl_i.load_tgt) begin
        target_q <= value_i;
      end
      if (ctrl_i.load_meas) begin
        meas_q <= value_i;
      end
      if (ctrl_i.step_upd) begin
        integ_q <= integ_d;
        if (ctrl_i.fresh) begin
          deriv_q    <= deriv_d;
          last_err_q <= err_q;
        end
      end
    end
  end

  // datapath pipeline registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step_err) begin
      err_q <= err_d;
    end
    if (ctrl_i.step_mul) begin
      sq_q  <= sq_d;
      itp_q <= itp_d;
      drv_q <= drv_d;
    end
    if (ctrl_i.step_term) begin
      pt_q <= pt_d;
      it_q <= it_d;
      dt_q <= dt_d;
    end
    if (ctrl_i.step_sum) begin
      u_q <= u_d;
    end
    if (ctrl_i.step_mass) begin
      ph_q <= ph_d;
      pl_q <= pl_d;
    end
  end

endmodule

/* hw/rtl/tpci_merge.sv */
// merge stage: error norm over all lanes against the squared limit
module tpci_merge (
  input  logic                        clk_i,
  input  tpci_pkg::ctrl_t             ctrl_i,
  input  logic [63:0]                 sq_i [tpci_pkg::NumAxes],
  input  logic [30:0]                 lim_i,
  output logic                        band_o
);
  import tpci_pkg::*;

  logic [63:0] sum_q, sum_d;
  logic [61:0] lim_sq_q, lim_sq_d;
  logic        band_q, band_d;

  // sum of squares cannot overflow 64 bits for three axes
  assign sum_d    = sq_i[0] + sq_i[1] + sq_i[2];
  assign lim_sq_d = 62'(lim_i) * 62'(lim_i);
  assign band_d   = sum_q < {2'b00, lim_sq_q};
  assign band_o   = band_q;

  // norm then compare, one step each
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step_norm) begin
      sum_q    <= sum_d;
      lim_sq_q <= lim_sq_d;
    end
    if (ctrl_i.step_cmp) begin
      band_q <= band_d;
    end
  end

endmodule

/* hw/rtl/three_axis_pid_conditional_integral_top.sv */
// top level: sequencer, configuration registers, axis lanes and result register
//
// Three-axis PID force controller in Q16.16. Set-target and measurement
// transactions are taken while idle and produce no result. A tick
// transaction runs a nine-step sequence through the three axis lanes and
// the norm merge stage (error, products, norm sum, norm compare, integral
// and derivative update, gain terms, sum, mass partial products, output),
// so a tick occupies the block until the sequence ends, including any wait
// of the result register on a stalled output; in_stall_o is high for that time.
// The result register lets a set or measurement transaction be taken while
// a finished force vector waits. Configuration is written through a plain
// write port and takes effect at once; write only while idle.
module three_axis_pid_conditional_integral_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tpci_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tpci_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [tpci_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpci_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import tpci_pkg::*;

  state_e    state_q, state_d;
  cfg_t      cfg_q;
  ctrl_t     ctrl;
  logic      fresh_q, fresh_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;
  logic      out_load, in_accept, band;

  logic signed [31:0] value [NumAxes];
  logic [63:0]        sq [NumAxes];
  logic signed [31:0] force_v [NumAxes];

  assign value[0] = in_data_i.value_x;
  assign value[1] = in_data_i.value_y;
  assign value[2] = in_data_i.value_z;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain        <= PropGainRst;
      cfg_q.integ_gain       <= IntegGainRst;
      cfg_q.deriv_gain       <= DerivGainRst;
      cfg_q.step_time        <= StepTimeRst;
      cfg_q.step_rate        <= StepRateRst;
      cfg_q.integral_limit   <= IntegLimRst;
      cfg_q.error_norm_limit <= NormLimRst;
      cfg_q.mass_scale       <= MassScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PROP_GAIN:   cfg_q.prop_gain        <= cfg_wdata_i[15:0];
        CFG_INTEG_GAIN:  cfg_q.integ_gain       <= cfg_wdata_i[15:0];
        CFG_DERIV_GAIN:  cfg_q.deriv_gain       <= cfg_wdata_i[15:0];
        CFG_STEP_TIME:   cfg_q.step_time        <= cfg_wdata_i[15:0];
        CFG_STEP_RATE:   cfg_q.step_rate        <= cfg_wdata_i[15:0];
        CFG_INTEG_LIMIT: cfg_q.integral_limit   <= cfg_wdata_i[30:0];
        CFG_NORM_LIMIT:  cfg_q.error_norm_limit <= cfg_wdata_i[30:0];
        CFG_MASS_SCALE:  cfg_q.mass_scale       <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer next state and step strobes
  always_comb begin
    state_d  = state_q;
    fresh_d  = fresh_q;
    out_load = 1'b0;
    ctrl     = '0;
    ctrl.fresh = fresh_q;
    ctrl.band  = band;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (action_e'(in_data_i.action))
            ACT_SET_TARGET: ctrl.load_tgt = 1'b1;
            ACT_MEASURE: begin
              ctrl.load_meas = 1'b1;
              fresh_d        = 1'b1;
            end
            ACT_TICK: state_d = ST_ERR;
            default: ;
          endcase
        end
      end
      ST_ERR: begin
        ctrl.step_err = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        ctrl.step_mul = 1'b1;
        state_d       = ST_NORM;
      end
      ST_NORM: begin
        ctrl.step_norm = 1'b1;
        state_d        = ST_CMP;
      end
      ST_CMP: begin
        ctrl.step_cmp = 1'b1;
        state_d       = ST_UPD;
      end
      ST_UPD: begin
        ctrl.step_upd = 1'b1;
        fresh_d       = 1'b0;
        state_d       = ST_TERM;
      end
      ST_TERM: begin
        ctrl.step_term = 1'b1;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        ctrl.step_sum = 1'b1;
        state_d       = ST_MASS;
      end
      ST_MASS: begin
        ctrl.step_mass = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        // wait while an earlier result is still held
        if (!(out_valid_q && out_stall_i)) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer and flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fresh_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  // axis lanes
  for (genvar a = 0; a < NumAxes; a++) begin : g_lane
    tpci_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .cfg_i   (cfg_q),
      .value_i (value[a]),
      .sq_o    (sq[a]),
      .force_o (force_v[a])
    );
  end

  // norm merge
  tpci_merge u_merge (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .sq_i   (sq),
    .lim_i  (cfg_q.error_norm_limit),
    .band_o (band)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.force_x <= force_v[0];
      out_q.force_y <= force_v[1];
      out_q.force_z <= force_v[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a tick transaction starts the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_data_i.action == ACT_TICK) |=> state_q == ST_ERR)
    else $error("tick did not start the sequence");

  // a new result appears only out of the output step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output step");

  // the output step never overwrites a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("held result overwritten");

  // the update step consumes the fresh sample flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |=> !fresh_q)
    else $error("fresh sample flag not cleared");

endmodule

/* tb/sv/tb_three_axis_pid_conditional_integral_top.sv */
// testbench for the three-axis pid force controller with conditional integration
module tb_three_axis_pid_conditional_integral_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tpci_pkg::*;

  localparam logic [1:0]         ActUnused   = 2'd3;
  localparam logic signed [31:0] MaxQ        = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MinQ        = 32'sh8000_0000;
  localparam logic signed [31:0] One         = 32'sh0001_0000;
  localparam longint             MaxWide     = 64'sd2147483647;
  localparam longint             MinWide     = -64'sd2147483648;
  localparam int                 PhaseItems  = 206;
  localparam int                 DrainCycles = 16;
  localparam int                 CycleLimit  = 400000;
  localparam int                 PlanRows    = 24;

  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        pinned;
    out_item_t   want;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // predictor state and its copy of the registers
  cfg_t               model_cfg;
  logic signed [31:0] tgt_vec      [NumAxes];
  logic signed [31:0] meas_vec     [NumAxes];
  logic signed [31:0] integ_vec    [NumAxes];
  logic signed [31:0] last_err_vec [NumAxes];
  logic signed [31:0] deriv_vec    [NumAxes];
  logic               fresh_flag;

  out_item_t   force_q [$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          send_burst;
  bit          recv_burst;
  plan_row_t   plan [PlanRows];

  three_axis_pid_conditional_integral_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt <= CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_cnt++;
    $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want, cycle_cnt);
  endtask

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > MaxWide) return MaxQ;
    if (x < MinWide) return MinQ;
    return x[31:0];
  endfunction

  // advance the controller state by one transaction; returns 1 when a force comes out
  function automatic bit predict_force(input in_item_t item, output out_item_t force_v);
    longint            e [NumAxes];
    logic signed [31:0] f [NumAxes];
    longint unsigned   mag, norm_sq, lim, lim_sq;
    longint            acc, ilim, st, rate, kp, ki, kd, ms, sum, u;
    force_v = '0;
    if (item.action == ACT_SET_TARGET) begin
      tgt_vec[0] = item.value_x;
      tgt_vec[1] = item.value_y;
      tgt_vec[2] = item.value_z;
      return 1'b0;
    end
    if (item.action == ACT_MEASURE) begin
      meas_vec[0] = item.value_x;
      meas_vec[1] = item.value_y;
      meas_vec[2] = item.value_z;
      fresh_flag  = 1'b1;
      return 1'b0;
    end
    if (item.action != ACT_TICK) return 1'b0;

    lim    = model_cfg.error_norm_limit;
    lim_sq = lim * lim;
    ilim   = model_cfg.integral_limit;
    st     = model_cfg.step_time;
    rate   = model_cfg.step_rate;
    kp     = model_cfg.prop_gain;
    ki     = model_cfg.integ_gain;
    kd     = model_cfg.deriv_gain;
    ms     = model_cfg.mass_scale;

    // error and squared norm
    norm_sq = 0;
    for (int k = 0; k < NumAxes; k++) begin
      e[k]    = clip32(longint'(tgt_vec[k]) - longint'(meas_vec[k]));
      mag     = (e[k] < 0) ? -e[k] : e[k];
      norm_sq += mag * mag;
    end

    // integrate inside the error band, clear outside it
    for (int k = 0; k < NumAxes; k++) begin
      if (norm_sq < lim_sq) begin
        acc = integ_vec[k] + ((e[k] * st) >>> 16);
        if (acc > ilim) acc = ilim;
        if (acc < -ilim) acc = -ilim;
        integ_vec[k] = acc[31:0];
      end else begin
        integ_vec[k] = '0;
      end
    end

    // derivative only on a new measurement
    if (fresh_flag) begin
      for (int k = 0; k < NumAxes; k++) begin
        deriv_vec[k]    = clip32((e[k] - last_err_vec[k]) * rate);
        last_err_vec[k] = e[k][31:0];
      end
      fresh_flag = 1'b0;
    end

    // gain terms, then mass scaling
    for (int k = 0; k < NumAxes; k++) begin
      sum  = kp * e[k] + ki * integ_vec[k] + kd * deriv_vec[k];
      u    = sum >>> 8;
      f[k] = clip32((u * ms) >>> 8);
    end
    force_v.force_x = f[0];
    force_v.force_y = f[1];
    force_v.force_z = f[2];
    return 1'b1;
  endfunction

  function automatic logic [31:0] extreme_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 32'h0000_0001;
      2: return MaxQ;
      3: return MinQ;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // measurement component, mostly inside the integration band around the target
  function automatic logic [31:0] near_value(input logic [31:0] base);
    longint unsigned span;
    int unsigned     r;
    span = 64'(model_cfg.error_norm_limit >> 1);
    if (span == 0) span = 65536;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom();
    if (r == 1) return extreme_value();
    if (r < 4) return base + $urandom_range(0, 64) - 32;
    return 32'(base + $urandom_range(0, 32'(2 * span)) - span);
  endfunction

  function automatic logic [31:0] target_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return extreme_value();
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t    item;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      item.action  = ACT_SET_TARGET;
      item.value_x = target_value();
      item.value_y = target_value();
      item.value_z = target_value();
    end else if (r < 50) begin
      item.action  = ACT_MEASURE;
      item.value_x = near_value(tgt_vec[0]);
      item.value_y = near_value(tgt_vec[1]);
      item.value_z = near_value(tgt_vec[2]);
    end else begin
      item.action  = (r < 96) ? ACT_TICK : ActUnused;
      item.value_x = $urandom();
      item.value_y = $urandom();
      item.value_z = $urandom();
    end
    return item;
  endfunction

  function automatic logic [15:0] pick_u16();
    return $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 1023));
  endfunction

  function automatic logic [30:0] pick_limit();
    return ($urandom_range(0, 2) != 0) ? 31'($urandom_range(0, 32'h000A_0000)) : 31'($urandom());
  endfunction

  function automatic cfg_t rand_setting();
    cfg_t s;
    s.prop_gain        = pick_u16();
    s.integ_gain       = pick_u16();
    s.deriv_gain       = pick_u16();
    s.mass_scale       = pick_u16();
    s.step_time        = pick_u16();
    s.step_rate        = $urandom_range(0, 1) ? 16'($urandom_range(1, 200))
                                              : 16'($urandom_range(1, 65535));
    s.integral_limit   = pick_limit();
    s.error_norm_limit = pick_limit();
    return s;
  endfunction

  // offer one transaction after a random gap; predict on acceptance
  task automatic send_item(input in_item_t item, input bit pinned, input out_item_t want);
    int unsigned gap;
    out_item_t   f;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_force(item, f)) force_q.push_back(pinned ? want : f);
  endtask

  // stop offering and wait for every pending force
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (force_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic load_setting(input cfg_t s);
    write_reg(CFG_PROP_GAIN, 31'(s.prop_gain));
    write_reg(CFG_INTEG_GAIN, 31'(s.integ_gain));
    write_reg(CFG_DERIV_GAIN, 31'(s.deriv_gain));
    write_reg(CFG_STEP_TIME, 31'(s.step_time));
    write_reg(CFG_STEP_RATE, 31'(s.step_rate));
    write_reg(CFG_INTEG_LIMIT, s.integral_limit);
    write_reg(CFG_NORM_LIMIT, s.error_norm_limit);
    write_reg(CFG_MASS_SCALE, 31'(s.mass_scale));
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    model_cfg = s;
  endtask

  task automatic run_phase(input cfg_t s);
    in_item_t item;
    int       done;
    drain();
    load_setting(s);
    done = 0;
    while (done < PhaseItems) begin
      item = random_item();
      if (item.action != ActUnused) done++;
      send_item(item, 1'b0, '0);
    end
  endtask

  // force receiver: random stalls, two long hold-offs, field checks
  initial begin : force_sink
    int unsigned wait_left;
    int unsigned hold_left;
    int unsigned taken;
    out_item_t   want;
    out_stall_i = 1'b0;
    wait_left   = 0;
    hold_left   = 0;
    taken       = 0;
    recv_burst  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (force_q.size() == 0) begin
          report_mismatch("unexpected force transaction", out_data_o.force_x, '0);
        end else begin
          want = force_q.pop_front();
          if (out_data_o.force_x !== want.force_x)
            report_mismatch("force_x", out_data_o.force_x, want.force_x);
          if (out_data_o.force_y !== want.force_y)
            report_mismatch("force_y", out_data_o.force_y, want.force_y);
          if (out_data_o.force_z !== want.force_z)
            report_mismatch("force_z", out_data_o.force_z, want.force_z);
        end
        taken++;
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        wait_left = recv_burst ? 0 : $urandom_range(0, 19);
        if (taken == 40 || taken == 400) hold_left = 300;
      end
      @(negedge clk_i);
      out_stall_i <= (hold_left != 0) || (wait_left != 0);
      if (hold_left != 0) hold_left--;
      else if (wait_left != 0) wait_left--;
    end
  end

  // main sequence
  initial begin : stimulus
    cfg_t s;
    in_item_t item;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_PROP_GAIN;
    cfg_wdata_i  = '0;
    mismatch_cnt = 0;
    send_burst   = 1'b0;
    model_cfg    = '{PropGainRst, IntegGainRst, DerivGainRst, StepTimeRst,
                     StepRateRst, IntegLimRst, NormLimRst, MassScaleRst};
    fresh_flag   = 1'b0;
    for (int k = 0; k < NumAxes; k++) begin
      tgt_vec[k]      = '0;
      meas_vec[k]     = '0;
      integ_vec[k]    = '0;
      last_err_vec[k] = '0;
      deriv_vec[k]    = '0;
    end

    // directed rows at reset settings
    plan = '{
      '{ACT_TICK, '0, '0, '0, 1'b1, '0},
      '{ActUnused, MaxQ, MinQ, 32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b1, '0},
      '{ACT_SET_TARGET, One, -One, 32'h0000_8000, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b0, '0},
      '{ACT_MEASURE, '0, '0, '0, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b0, '0},
      '{ACT_MEASURE, 32'h0000_F000, 32'hFFFF_1000, 32'h0000_7000, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b0, '0},
      '{ACT_SET_TARGET, MaxQ, MaxQ, MaxQ, 1'b0, '0},
      '{ACT_MEASURE, MinQ, MinQ, MinQ, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b1, '{MaxQ, MaxQ, MaxQ}},
      '{ACT_SET_TARGET, MinQ, MinQ, MinQ, 1'b0, '0},
      '{ACT_MEASURE, MaxQ, MaxQ, MaxQ, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b1, '{MinQ, MinQ, MinQ}},
      '{ACT_SET_TARGET, '0, '0, '0, 1'b0, '0},
      '{ACT_MEASURE, '0, '0, '0, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b0, '0},
      '{ACT_SET_TARGET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{ACT_TICK, '0, '0, '0, 1'b0, '0},
      '{ACT_MEASURE, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PlanRows; i++) begin
      item.action  = plan[i].act;
      item.value_x = plan[i].vx;
      item.value_y = plan[i].vy;
      item.value_z = plan[i].vz;
      send_item(item, plan[i].pinned, plan[i].want);
    end
    send_item('{ACT_TICK, '0, '0, '0}, 1'b0, '0);

    // random phases over several register settings
    s = rand_setting();
    s.step_time = 16'hC000;
    run_phase(s);
    s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
          31'h7FFF_FFFF, 31'h7FFF_FFFF, 16'hFFFF};
    run_phase(s);
    s = '0;
    run_phase(s);
    s = rand_setting();
    s.error_norm_limit = '0;
    run_phase(s);
    s = rand_setting();
    s.integral_limit = '0;
    run_phase(s);
    s = rand_setting();
    s.step_time = '0;
    s.step_rate = '0;
    run_phase(s);
    run_phase(rand_setting());
    run_phase(rand_setting());
    s = '{PropGainRst, IntegGainRst, DerivGainRst, StepTimeRst,
          StepRateRst, IntegLimRst, NormLimRst, MassScaleRst};
    run_phase(s);

    drain();
    if (mismatch_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* three_axis_pid_conditional_integral_top.f */
hw/rtl/tpci_pkg.sv
hw/rtl/tpci_lane.sv
hw/rtl/tpci_merge.sv
hw/rtl/three_axis_pid_conditional_integral_top.sv
tb/sv/tb_three_axis_pid_conditional_integral_top.sv
